FILE: hw/rtl/slcfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Shared constants for the sync/length/CRC frame parser: CRC-16 settings,
// field widths and parser state codes.
// ----------------------------------------------------------------------------
package slcfp_pkg;

	// Default largest payload that a frame may carry.
	localparam int MAX_PAYLOAD_DEF = 64;

	// Width of the frame length field on the result side.
	localparam int LEN_W = 7;

	// CRC-16 with polynomial 0x1021, preset to all ones, MSB first.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// Sync byte after reset.
	localparam logic [7:0] SYNC_RST = 8'hAA;

	// Parser state codes.
	localparam logic [3:0] ST_HUNT    = 4'd0;
	localparam logic [3:0] ST_TYPE    = 4'd1;
	localparam logic [3:0] ST_LEN_LO  = 4'd2;
	localparam logic [3:0] ST_LEN_HI  = 4'd3;
	localparam logic [3:0] ST_PAYLOAD = 4'd4;
	localparam logic [3:0] ST_CRC_LO  = 4'd5;
	localparam logic [3:0] ST_CRC_HI  = 4'd6;
	localparam logic [3:0] ST_RP_READ = 4'd7;
	localparam logic [3:0] ST_RP_LOAD = 4'd8;

endpackage

FILE: hw/rtl/slcfp_crc_byte.sv
// ----------------------------------------------------------------------------
// CRC-16 byte update
// Folds one byte into a running CRC-16 (polynomial 0x1021), MSB first.
// ----------------------------------------------------------------------------
module slcfp_crc_byte import slcfp_pkg::*; (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	// Eight shift-and-reduce steps, one per data bit.
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

FILE: hw/rtl/sync_length_crc_frame_parser.sv
// ----------------------------------------------------------------------------
// Sync/length/CRC frame parser
// Hunts for a sync byte, collects type, length, payload and CRC-16, and
// replays checked frames one payload byte per result.
// ----------------------------------------------------------------------------
// Received bytes are accepted while the frame is being collected; the CRC
// is folded in byte by byte as it arrives. On a good frame with payload,
// the payload memory (one synchronous read port) is replayed result by
// result, each byte first read from the memory and then loaded into the
// output register once it is free, and the input is stalled until the last
// byte is loaded. Empty frames and CRC errors load their single result at
// the edge that takes the last CRC byte; that byte waits while the output
// register still holds a result not yet taken. The payload memory needs no
// clearing after reset.
module sync_length_crc_frame_parser import slcfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// Received byte channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  frame_type,
	output logic [6:0]  frame_length,
	output logic        has_data,
	output logic [5:0]  byte_index,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic [31:0] good_frames,
	output logic [31:0] crc_errors
);

	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	logic [3:0]       state_q;
	logic [7:0]       sync_q;
	logic [7:0]       type_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] rd_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_lo_q;
	logic [31:0]      good_q;
	logic [31:0]      err_q;

	logic [7:0]       mem [MAX_PAYLOAD];
	logic [7:0]       rd_data_q;

	logic             out_valid_q;
	logic             status_q;
	logic [7:0]       frame_type_q;
	logic [LEN_W-1:0] frame_length_q;
	logic             has_data_q;
	logic [5:0]       byte_index_q;
	logic [7:0]       data_byte_q;
	logic             last_q;
	logic [31:0]      good_out_q;
	logic [31:0]      err_out_q;

	logic             in_acc;
	logic             out_take;
	logic             out_free;
	logic             out_load;
	logic [15:0]      crc_nxt;
	logic [CNT_W-1:0] fill_nxt;
	logic             crc_match;
	logic             rd_last;
	logic             wr_en;

	// The configuration register is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RST;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	// Handshake terms.
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || out_take;
	assign in_stall = (state_q == ST_RP_READ) || (state_q == ST_RP_LOAD) ||
		((state_q == ST_CRC_HI) && !out_free);
	assign in_acc   = in_valid && !in_stall;

	// Byte-wise CRC update.
	slcfp_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_nxt)
	);

	assign fill_nxt  = fill_q + 1'b1;
	assign crc_match = ({rx_byte, crc_lo_q} == crc_q);
	assign rd_last   = (LEN_W'(rd_q) == (len_q - 1'b1));
	assign wr_en     = in_acc && (state_q == ST_PAYLOAD);

	// A result is loaded for an empty good frame or a CRC error at the last
	// CRC byte, and for every replayed payload byte.
	assign out_load = ((state_q == ST_CRC_HI) && in_acc && (!crc_match || (len_q == '0))) ||
		((state_q == ST_RP_LOAD) && out_free);

	// Output valid flag: set on a load, cleared on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload memory: written while collecting, read only during replay, so
	// a write and a read never meet on the same entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RP_READ) begin
			rd_data_q <= mem[rd_q];
		end
	end

	// Parser and replay sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_HUNT;
			type_q         <= '0;
			len_q          <= '0;
			fill_q         <= '0;
			rd_q           <= '0;
			crc_q          <= CRC_INIT;
			crc_lo_q       <= '0;
			good_q         <= '0;
			err_q          <= '0;
			status_q       <= 1'b0;
			frame_type_q   <= '0;
			frame_length_q <= '0;
			has_data_q     <= 1'b0;
			byte_index_q   <= '0;
			data_byte_q    <= '0;
			last_q         <= 1'b0;
			good_out_q     <= '0;
			err_out_q      <= '0;
		end else begin
			unique case (state_q)
				ST_TYPE: begin
					if (in_acc) begin
						type_q  <= rx_byte;
						crc_q   <= crc_nxt;
						state_q <= ST_LEN_LO;
					end
				end
				ST_LEN_LO: begin
					if (in_acc) begin
						len_q   <= rx_byte[LEN_W-1:0];
						crc_lo_q <= rx_byte;
						crc_q   <= crc_nxt;
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: begin
					// The low length byte was parked in crc_lo_q for the range check.
					if (in_acc) begin
						crc_q  <= crc_nxt;
						fill_q <= '0;
						if ((rx_byte != 8'h00) || (crc_lo_q > 8'(MAX_PAYLOAD))) begin
							state_q <= ST_HUNT;
						end else if (len_q == '0) begin
							state_q <= ST_CRC_LO;
						end else begin
							state_q <= ST_PAYLOAD;
						end
					end
				end
				ST_PAYLOAD: begin
					if (in_acc) begin
						crc_q  <= crc_nxt;
						fill_q <= fill_nxt;
						if (LEN_W'(fill_nxt) >= len_q) begin
							state_q <= ST_CRC_LO;
						end
					end
				end
				ST_CRC_LO: begin
					if (in_acc) begin
						crc_lo_q <= rx_byte;
						state_q  <= ST_CRC_HI;
					end
				end
				ST_CRC_HI: begin
					if (in_acc) begin
						state_q <= ST_HUNT;
						rd_q    <= '0;
						if (crc_match) begin
							good_q <= good_q + 1'b1;
							if (len_q == '0) begin
								status_q       <= 1'b0;
								frame_type_q   <= type_q;
								frame_length_q <= len_q;
								has_data_q     <= 1'b0;
								byte_index_q   <= '0;
								data_byte_q    <= '0;
								last_q         <= 1'b1;
								good_out_q     <= good_q + 1'b1;
								err_out_q      <= err_q;
							end else begin
								state_q <= ST_RP_READ;
							end
						end else begin
							err_q          <= err_q + 1'b1;
							status_q       <= 1'b1;
							frame_type_q   <= type_q;
							frame_length_q <= len_q;
							has_data_q     <= 1'b0;
							byte_index_q   <= '0;
							data_byte_q    <= '0;
							last_q         <= 1'b1;
							good_out_q     <= good_q;
							err_out_q      <= err_q + 1'b1;
						end
					end
				end
				ST_RP_READ: begin
					state_q <= ST_RP_LOAD;
				end
				ST_RP_LOAD: begin
					// Wait for the output register, then load the byte just read.
					if (out_free) begin
						status_q       <= 1'b0;
						frame_type_q   <= type_q;
						frame_length_q <= len_q;
						has_data_q     <= 1'b1;
						byte_index_q   <= 6'(rd_q);
						data_byte_q    <= rd_data_q;
						last_q         <= rd_last;
						good_out_q     <= good_q;
						err_out_q      <= err_q;
						if (rd_last) begin
							state_q <= ST_HUNT;
						end else begin
							rd_q    <= rd_q + 1'b1;
							state_q <= ST_RP_READ;
						end
					end
				end
				default: begin
					// Hunting, and any unused code, looks for the sync byte.
					if (in_acc) begin
						state_q <= ST_HUNT;
						if (rx_byte == sync_q) begin
							crc_q   <= CRC_INIT;
							state_q <= ST_TYPE;
						end
					end
				end
			endcase
		end
	end

	// Result outputs.
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_type   = frame_type_q;
	assign frame_length = frame_length_q;
	assign has_data     = has_data_q;
	assign byte_index   = byte_index_q;
	assign data_byte    = data_byte_q;
	assign last         = last_q;
	assign good_frames  = good_out_q;
	assign crc_errors   = err_out_q;

`ifndef SYNTHESIS
	// The good-frame count moves only on a transfer of the last CRC byte.
	a_good_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && (state_q == ST_CRC_HI)) |=> $stable(good_q))
		else $error("good frame count changed outside frame end");

	// Replay never reads past the frame length.
	a_replay_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RP_LOAD) |-> (LEN_W'(rd_q) < len_q))
		else $error("replay index beyond frame length");

	// Payload writes stay below the frame length.
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAYLOAD) |-> (LEN_W'(fill_q) < len_q))
		else $error("payload fill index beyond frame length");
`endif

endmodule
